// ----- src/sha256_stream_hasher_top_defines.svh -----
// Assertion macros shared by the hasher's checker.
// No dependencies; include by bare file name.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define SHS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/shs_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 stream hasher.
// No dependencies.
`default_nettype none

package shs_pkg;

    // One 32-bit message word on its way from front to back
    typedef struct packed {
        logic [31:0] word;
        logic        last;    // final word of the message's last block
    } t_qitem;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LEN_POS       = 6'd56;   // first length byte in a block
    localparam logic [5:0] LAST_POS      = 6'h3f;   // last byte of a block
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [3:0] LAST_LOAD     = 4'hf;    // last of sixteen block words
    localparam logic [2:0] LAST_WORD_IDX = 3'd7;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] ch(input logic [31:0] e, input logic [31:0] f,
                                       input logic [31:0] g);
        ch = (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] maj(input logic [31:0] a, input logic [31:0] b,
                                        input logic [31:0] c);
        maj = (a & b) ^ (a & c) ^ (b & c);
    endfunction

    // Initial hash words
    function automatic logic [31:0] iv_word(input logic [2:0] idx);
        case (idx)
            3'd0:    iv_word = 32'h6a09e667;
            3'd1:    iv_word = 32'hbb67ae85;
            3'd2:    iv_word = 32'h3c6ef372;
            3'd3:    iv_word = 32'ha54ff53a;
            3'd4:    iv_word = 32'h510e527f;
            3'd5:    iv_word = 32'h9b05688c;
            3'd6:    iv_word = 32'h1f83d9ab;
            default: iv_word = 32'h5be0cd19;
        endcase
    endfunction

    // Round constants
    function automatic logic [31:0] k_word(input logic [5:0] idx);
        case (idx)
            6'd0:  k_word = 32'h428a2f98;  6'd1:  k_word = 32'h71374491;
            6'd2:  k_word = 32'hb5c0fbcf;  6'd3:  k_word = 32'he9b5dba5;
            6'd4:  k_word = 32'h3956c25b;  6'd5:  k_word = 32'h59f111f1;
            6'd6:  k_word = 32'h923f82a4;  6'd7:  k_word = 32'hab1c5ed5;
            6'd8:  k_word = 32'hd807aa98;  6'd9:  k_word = 32'h12835b01;
            6'd10: k_word = 32'h243185be;  6'd11: k_word = 32'h550c7dc3;
            6'd12: k_word = 32'h72be5d74;  6'd13: k_word = 32'h80deb1fe;
            6'd14: k_word = 32'h9bdc06a7;  6'd15: k_word = 32'hc19bf174;
            6'd16: k_word = 32'he49b69c1;  6'd17: k_word = 32'hefbe4786;
            6'd18: k_word = 32'h0fc19dc6;  6'd19: k_word = 32'h240ca1cc;
            6'd20: k_word = 32'h2de92c6f;  6'd21: k_word = 32'h4a7484aa;
            6'd22: k_word = 32'h5cb0a9dc;  6'd23: k_word = 32'h76f988da;
            6'd24: k_word = 32'h983e5152;  6'd25: k_word = 32'ha831c66d;
            6'd26: k_word = 32'hb00327c8;  6'd27: k_word = 32'hbf597fc7;
            6'd28: k_word = 32'hc6e00bf3;  6'd29: k_word = 32'hd5a79147;
            6'd30: k_word = 32'h06ca6351;  6'd31: k_word = 32'h14292967;
            6'd32: k_word = 32'h27b70a85;  6'd33: k_word = 32'h2e1b2138;
            6'd34: k_word = 32'h4d2c6dfc;  6'd35: k_word = 32'h53380d13;
            6'd36: k_word = 32'h650a7354;  6'd37: k_word = 32'h766a0abb;
            6'd38: k_word = 32'h81c2c92e;  6'd39: k_word = 32'h92722c85;
            6'd40: k_word = 32'ha2bfe8a1;  6'd41: k_word = 32'ha81a664b;
            6'd42: k_word = 32'hc24b8b70;  6'd43: k_word = 32'hc76c51a3;
            6'd44: k_word = 32'hd192e819;  6'd45: k_word = 32'hd6990624;
            6'd46: k_word = 32'hf40e3585;  6'd47: k_word = 32'h106aa070;
            6'd48: k_word = 32'h19a4c116;  6'd49: k_word = 32'h1e376c08;
            6'd50: k_word = 32'h2748774c;  6'd51: k_word = 32'h34b0bcb5;
            6'd52: k_word = 32'h391c0cb3;  6'd53: k_word = 32'h4ed8aa4a;
            6'd54: k_word = 32'h5b9cca4f;  6'd55: k_word = 32'h682e6ff3;
            6'd56: k_word = 32'h748f82ee;  6'd57: k_word = 32'h78a5636f;
            6'd58: k_word = 32'h84c87814;  6'd59: k_word = 32'h8cc70208;
            6'd60: k_word = 32'h90befffa;  6'd61: k_word = 32'ha4506ceb;
            6'd62: k_word = 32'hbef9a3f7;  6'd63: k_word = 32'hc67178f2;
            default: k_word = 32'h0;
        endcase
    endfunction

endpackage

`default_nettype wire

// ----- src/shs_front.sv -----
// Front end: takes message bytes, packs them into words, appends the padding
// and the bit length. Depends on shs_pkg.
`default_nettype none

module shs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_data_byte,
    input  logic           i_end_of_message,
    output logic           o_q_valid,
    input  logic           i_q_ready,
    output shs_pkg::t_qitem o_q_item
);
    import shs_pkg::*;

    typedef enum logic [3:0] {
        F_ACCEPT  = 4'b0001,
        F_PAD80   = 4'b0010,
        F_PADZERO = 4'b0100,
        F_PADLEN  = 4'b1000
    } t_fstate;

    t_fstate      r_state, n_state;
    logic [5:0]   r_pos, n_pos;            // byte position within the block
    logic [60:0]  r_byte_cnt, n_byte_cnt;  // message length in bytes, mod 2^61
    logic [23:0]  r_word, n_word;          // first three bytes of the current word

    logic         word_end;
    logic         step_ok;
    logic         step;
    logic [7:0]   cur_byte;
    logic [63:0]  msg_bits;
    logic [7:0]   len_byte;
    logic [5:0]   pos_inc;

    // A step that closes a word needs room in the queue
    assign word_end   = (r_pos[1:0] == 2'b11);
    assign step_ok    = !word_end || i_q_ready;
    assign o_in_ready = (r_state == F_ACCEPT) && step_ok;
    assign pos_inc    = r_pos + 6'd1;

    // Big-endian length byte for positions 56..63
    assign msg_bits = {r_byte_cnt, 3'b000};
    assign len_byte = 8'(msg_bits >> {~r_pos[2:0], 3'b000});

    // Byte source and sequencing
    always_comb begin
        n_state    = r_state;
        n_byte_cnt = r_byte_cnt;
        cur_byte   = i_data_byte;
        step       = 1'b0;
        unique case (r_state)
            F_ACCEPT: begin
                step = i_in_valid && step_ok;
                if (step) begin
                    n_byte_cnt = r_byte_cnt + 61'd1;
                    if (i_end_of_message) begin
                        n_state = F_PAD80;
                    end
                end
            end
            F_PAD80: begin
                cur_byte = PAD_BYTE;
                step     = step_ok;
                if (step) begin
                    n_state = (pos_inc == LEN_POS) ? F_PADLEN : F_PADZERO;
                end
            end
            F_PADZERO: begin
                cur_byte = 8'h00;
                step     = step_ok;
                if (step && (pos_inc == LEN_POS)) begin
                    n_state = F_PADLEN;
                end
            end
            F_PADLEN: begin
                cur_byte = len_byte;
                step     = step_ok;
                if (step && (r_pos == LAST_POS)) begin
                    n_state    = F_ACCEPT;
                    n_byte_cnt = '0;
                end
            end
            default: begin
                n_state = F_ACCEPT;
            end
        endcase
        n_pos  = step ? pos_inc : r_pos;
        n_word = step ? {r_word[15:0], cur_byte} : r_word;
    end

    // Word transfer to the queue
    assign o_q_valid     = word_end && ((r_state != F_ACCEPT) || i_in_valid);
    assign o_q_item.word = {r_word, cur_byte};
    assign o_q_item.last = (r_state == F_PADLEN) && (r_pos == LAST_POS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= F_ACCEPT;
            r_pos      <= '0;
            r_byte_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_byte_cnt <= n_byte_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

`default_nettype wire

// ----- src/shs_queue.sv -----
// Small register FIFO between the front end and the compression engine.
// No dependencies.
`default_nettype none

module shs_queue #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             push, pop;

    assign o_wr_ready = (r_count != CW'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- src/shs_back.sv -----
// Compression engine: loads sixteen words, runs one round per cycle, folds
// into the chaining value and shows the digest. Depends on shs_pkg.
`default_nettype none

module shs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_ready,
    input  shs_pkg::t_qitem i_q_item,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);
    import shs_pkg::*;

    typedef enum logic [3:0] {
        B_LOAD  = 4'b0001,
        B_ROUND = 4'b0010,
        B_FOLD  = 4'b0100,
        B_OUT   = 4'b1000
    } t_bstate;

    t_bstate     r_state, n_state;
    logic [5:0]  r_cnt, n_cnt;       // load word count, then round number
    logic        r_last, n_last;     // current block ends the message
    logic [2:0]  r_widx, n_widx;     // digest word on the output
    logic [31:0] r_chain [8];
    logic [31:0] r_v [8];            // working variables a..h
    logic [31:0] r_win [16];         // schedule window, r_win[0] is W[t]
    logic [31:0] r_hkw;              // h + K[t] + W[t] for the current round

    logic        pop;
    logic        load_done;
    logic [31:0] sched;
    logic [31:0] t1, t2;

    assign o_q_ready = (r_state == B_LOAD);
    assign pop       = o_q_ready && i_q_valid;
    assign load_done = pop && (r_cnt[3:0] == LAST_LOAD);

    // Next schedule word and round sums
    assign sched = ssig1(r_win[14]) + r_win[9] + ssig0(r_win[1]) + r_win[0];
    assign t1    = r_hkw + bsig1(r_v[4]) + ch(r_v[4], r_v[5], r_v[6]);
    assign t2    = bsig0(r_v[0]) + maj(r_v[0], r_v[1], r_v[2]);

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_last  = r_last;
        n_widx  = r_widx;
        unique case (r_state)
            B_LOAD: begin
                if (pop) begin
                    if (load_done) begin
                        n_state = B_ROUND;
                        n_cnt   = '0;
                        n_last  = i_q_item.last;
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
            end
            B_ROUND: begin
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == LAST_ROUND) begin
                    n_state = B_FOLD;
                end
            end
            B_FOLD: begin
                n_widx  = '0;
                n_state = r_last ? B_OUT : B_LOAD;
            end
            B_OUT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 3'd1;
                    if (r_widx == LAST_WORD_IDX) begin
                        n_state = B_LOAD;
                    end
                end
            end
            default: begin
                n_state = B_LOAD;
            end
        endcase
    end

    // Control and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_LOAD;
            r_cnt   <= '0;
            r_last  <= 1'b0;
            r_widx  <= '0;
            for (int i = 0; i < 8; i++) begin
                r_chain[i] <= iv_word(3'(i));
            end
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_last  <= n_last;
            r_widx  <= n_widx;
            if (r_state == B_FOLD) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= r_chain[i] + r_v[i];
                end
            end else if ((r_state == B_OUT) && i_out_ready && (r_widx == LAST_WORD_IDX)) begin
                for (int i = 0; i < 8; i++) begin
                    r_chain[i] <= iv_word(3'(i));
                end
            end
        end
    end

    // Window, working variables and the precomputed h + K + W
    always_ff @(posedge i_clk) begin
        if (pop) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= i_q_item.word;
            if (load_done) begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_chain[i];
                end
                r_hkw <= r_chain[7] + k_word(6'd0) + r_win[1];
            end
        end else if (r_state == B_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= sched;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
            r_hkw  <= r_v[6] + k_word(r_cnt + 6'd1) + r_win[1];
        end
    end

    // Digest words straight from the chaining registers
    assign o_out_valid   = (r_state == B_OUT);
    assign o_digest_word = r_chain[r_widx];
    assign o_word_index  = r_widx;
    assign o_last_word   = (r_widx == LAST_WORD_IDX);

endmodule

`default_nettype wire

// ----- src/sha256_stream_hasher_top.sv -----
// Top level of the SHA-256 stream hasher: front end, word queue, compression
// engine. Depends on shs_pkg, shs_front, shs_queue, shs_back.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready   | i_data_byte, i_end_of_message
//  out     | output    | o_out_valid / i_out_ready | o_digest_word, o_word_index, o_last_word
//
// A byte is taken while the front end accepts bytes and the word queue has room.
// The engine loads a block of sixteen words, runs 64 rounds and one fold, and
// takes no words from the queue meanwhile, while the front end keeps filling it.
// After the last byte the front end adds 9 to 72 padding bytes; the eight
// digest words then leave at one per cycle, held while i_out_ready is low.
// Synchronous active-low reset returns both halves to the initial hash state.
`default_nettype none

module sha256_stream_hasher_top #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import shs_pkg::*;

    t_qitem fe_item;
    t_qitem be_item;
    logic   fe_valid, fe_ready;
    logic   be_valid, be_ready;

    shs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_q_valid        (fe_valid),
        .i_q_ready        (fe_ready),
        .o_q_item         (fe_item)
    );

    shs_queue #(
        .WIDTH ($bits(t_qitem)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (fe_valid),
        .o_wr_ready (fe_ready),
        .i_wr_data  (fe_item),
        .o_rd_valid (be_valid),
        .i_rd_ready (be_ready),
        .o_rd_data  (be_item)
    );

    shs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (be_valid),
        .o_q_ready     (be_ready),
        .i_q_item      (be_item),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

endmodule

`default_nettype wire

// ----- src/shs_checker.sv -----
// Port-level checks on the hasher's digest output, bound to the top level.
// Depends on sha256_stream_hasher_top_defines.svh.
`default_nettype none
`include "sha256_stream_hasher_top_defines.svh"

module shs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_digest_word,
    input logic [2:0]  o_word_index,
    input logic        o_last_word
);

    // A stalled digest word holds
    `SHS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_digest_word) && $stable(o_word_index),
        "digest word changed while stalled")

    // Last flag marks exactly the eighth word
    `SHS_ASSERT_SAME(a_last_flag, i_clk, i_rst_n, o_out_valid,
        o_last_word == (o_word_index == 3'd7),
        "last_word does not match word_index")

    // Words of one digest follow without gaps and in order
    `SHS_ASSERT_NEXT(a_word_seq, i_clk, i_rst_n,
        o_out_valid && i_out_ready && !o_last_word,
        o_out_valid && (o_word_index == $past(o_word_index) + 3'd1),
        "digest words out of sequence")

    // A digest starts at its most significant word
    `SHS_ASSERT_SAME(a_digest_start, i_clk, i_rst_n, $rose(o_out_valid),
        o_word_index == 3'd0, "digest does not start at word 0")

endmodule

bind sha256_stream_hasher_top shs_checker u_shs_checker (.*);

`default_nettype wire

// ----- tb/sv/sha256_stream_hasher_top_tb.sv -----
// Self-checking testbench for sha256_stream_hasher_top: random byte messages in,
// digest words checked against an in-bench SHA-256 model. Needs only the RTL
// (sha256_stream_hasher_top and what it pulls in).
`default_nettype none

module sha256_stream_hasher_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned WATCHDOG_CYCLES = 200000;
    localparam int unsigned DRAIN_CYCLES    = 400;
    localparam int unsigned PHASE_CYCLES    = 450;
    localparam int unsigned RANDOM_BYTES    = 400;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam int unsigned LEN_START = 56;
    localparam int unsigned BLK_LAST  = 63;
    localparam logic [2:0] FINAL_IDX  = 3'd7;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    // Message lengths that land on the padding boundaries
    localparam int unsigned EDGE_LENS [8] = '{55, 56, 57, 63, 64, 65, 119, 120};

    typedef enum logic [1:0] {
        PH_FREE,
        PH_SRC_IDLE,
        PH_SNK_STALL,
        PH_BOTH
    } t_idle_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       eom;
    } t_msg_byte;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } t_digest_word;

    // DUT ports
    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_end_of_message = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    // Stimulus and checking state
    t_msg_byte    bytes_to_send[$];
    t_digest_word digests_due[$];
    int unsigned  bytes_total  = 0;
    int unsigned  bytes_taken  = 0;
    int unsigned  fails        = 0;
    int unsigned  cycle_count  = 0;
    logic         in_taken     = 1'b0;
    t_idle_phase  phase        = PH_FREE;

    // Hash model state
    logic [31:0] chain_words [8];
    logic [7:0]  msg_block   [64];
    logic [63:0] msg_bits;

    sha256_stream_hasher_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One 64-round compression of msg_block into chain_words
    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wi, t1, t2, s0, s1;
        int unsigned j;
        for (j = 0; j < 16; j++) begin
            w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
        end
        for (j = 0; j < 8; j++) begin
            v[j] = chain_words[j];
        end
        for (j = 0; j < 64; j++) begin
            if (j < 16) begin
                wi = w[j];
            end else begin
                s1 = ror32(w[(j-2)%16], 17) ^ ror32(w[(j-2)%16], 19) ^ (w[(j-2)%16] >> 10);
                s0 = ror32(w[(j-15)%16], 7) ^ ror32(w[(j-15)%16], 18) ^ (w[(j-15)%16] >> 3);
                wi = s1 + w[(j-7)%16] + s0 + w[j%16];
                w[j%16] = wi;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[j] + wi;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (j = 0; j < 8; j++) begin
            chain_words[j] = chain_words[j] + v[j];
        end
    endfunction

    function automatic void restart_hash();
        int unsigned j;
        for (j = 0; j < 8; j++) begin
            chain_words[j] = SHA_IV[j];
        end
        msg_bits = '0;
    endfunction

    // Absorb one accepted byte; on end of message pad, finish and queue the digest
    function automatic void absorb_byte(input logic [7:0] data, input logic eom);
        int unsigned fill, j;
        t_digest_word dw;
        fill = int'(msg_bits[8:3]);
        msg_block[fill] = data;
        msg_bits = msg_bits + 64'd8;
        if (fill == BLK_LAST) begin
            compress_block();
        end
        if (eom) begin
            fill = int'(msg_bits[8:3]);
            msg_block[fill] = PAD_MARK;
            for (j = fill + 1; j < 64; j++) begin
                msg_block[j] = 8'h00;
            end
            // no room for the length: it goes into an extra block
            if (fill >= LEN_START) begin
                compress_block();
                for (j = 0; j < LEN_START; j++) begin
                    msg_block[j] = 8'h00;
                end
            end
            for (j = 0; j < 8; j++) begin
                msg_block[LEN_START + j] = msg_bits[63 - 8*j -: 8];
            end
            compress_block();
            for (j = 0; j < 8; j++) begin
                dw.word = chain_words[j];
                dw.idx  = 3'(j);
                dw.last = (3'(j) == FINAL_IDX);
                digests_due.push_back(dw);
            end
            restart_hash();
        end
    endfunction

    function automatic void queue_byte(input logic [7:0] data, input logic eom);
        t_msg_byte mb;
        mb.data = data;
        mb.eom  = eom;
        bytes_to_send.push_back(mb);
        bytes_total++;
    endfunction

    function automatic int unsigned src_idle_pct(input t_idle_phase ph);
        case (ph)
            PH_SRC_IDLE: return 78;
            PH_BOTH:     return 14;
            default:     return 0;
        endcase
    endfunction

    function automatic int unsigned snk_stall_pct(input t_idle_phase ph);
        case (ph)
            PH_SNK_STALL: return 78;
            PH_BOTH:      return 14;
            default:      return 0;
        endcase
    endfunction

    // Byte driver and output-ready driver, both on the falling edge
    always @(negedge i_clk) begin : drive_inputs
        logic offer;
        t_msg_byte mb;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            offer = (bytes_to_send.size() > 0) &&
                    ($urandom_range(0, 99) >= src_idle_pct(phase));
            if (offer) begin
                mb = bytes_to_send.pop_front();
                i_data_byte      <= mb.data;
                i_end_of_message <= mb.eom;
            end
            i_in_valid <= offer;
        end
        i_out_ready <= ($urandom_range(0, 99) >= snk_stall_pct(phase));
    end

    // Input transfers feed the model; output transfers are checked in order
    always @(posedge i_clk) begin : watch_transfers
        t_digest_word want;
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                absorb_byte(i_data_byte, i_end_of_message);
                bytes_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                if (digests_due.size() == 0) begin
                    $error("unexpected digest word %h (index %0d)", o_digest_word, o_word_index);
                    fails++;
                end else begin
                    want = digests_due.pop_front();
                    if (o_digest_word !== want.word) begin
                        $error("digest_word: expected %h, actual %h", want.word, o_digest_word);
                        fails++;
                    end
                    if (o_word_index !== want.idx) begin
                        $error("word_index: expected %0d, actual %0d", want.idx, o_word_index);
                        fails++;
                    end
                    if (o_last_word !== want.last) begin
                        $error("last_word: expected %0b, actual %0b", want.last, o_last_word);
                        fails++;
                    end
                end
            end
        end
    end

    // Idle phase rotation and watchdog
    always @(posedge i_clk) begin : pace_run
        cycle_count <= cycle_count + 1;
        phase <= t_idle_phase'((cycle_count / PHASE_CYCLES) % 4);
        if (cycle_count >= WATCHDOG_CYCLES) begin
            $display("FAIL sha256_stream_hasher_top");
            $finish;
        end
    end

    initial begin : run_test
        int unsigned msg_len, pick, j;
        restart_hash();

        // Directed: byte extremes, single-byte messages, the "abc" vector, two short others
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hff, 1'b1);
        queue_byte(8'h61, 1'b0);
        queue_byte(8'h62, 1'b0);
        queue_byte(8'h63, 1'b1);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h7f, 1'b1);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'haa, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hfe, 1'b1);

        // Random messages, biased toward short ones and padding boundaries
        while (bytes_total < RANDOM_BYTES) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
                msg_len = $urandom_range(1, 16);
            end else if (pick < 7) begin
                msg_len = EDGE_LENS[$urandom_range(0, 7)];
            end else begin
                msg_len = $urandom_range(1, 140);
            end
            for (j = 1; j <= msg_len; j++) begin
                queue_byte(8'($urandom_range(0, 255)), j == msg_len);
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (bytes_taken < bytes_total) @(posedge i_clk);
        while (digests_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fails == 0) begin
            $display("PASS sha256_stream_hasher_top");
        end else begin
            $display("FAIL sha256_stream_hasher_top");
        end
        $finish;
    end

endmodule

`default_nettype wire
